>>> design/rtsc_pkg.sv
// Shared types, widths and constants for the resistive touch scan controller.
`timescale 1ns / 1ps
`default_nettype none
package rtsc_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int SAMPLE_W = 12;
    localparam int TICK_W   = 16;
    localparam int POS_W    = 13;
    localparam int SIZE_W   = 13;
    localparam int PROD_W   = SAMPLE_W + SIZE_W;
    localparam int QUO_W    = SIZE_W;

    localparam int DEF_SCREEN_WIDTH  = 480;
    localparam int DEF_SCREEN_HEIGHT = 272;

    localparam logic [SAMPLE_W-1:0] RST_MIN_X = 12'd190;
    localparam logic [SAMPLE_W-1:0] RST_MAX_X = 12'd3900;
    localparam logic [SAMPLE_W-1:0] RST_MIN_Y = 12'd180;
    localparam logic [SAMPLE_W-1:0] RST_MAX_Y = 12'd3850;
    localparam logic [TICK_W-1:0]   RST_STEP  = 16'd1;
    localparam logic [TICK_W-1:0]   TICK_MAX  = 16'hFFFF;

    // pin order: x1, x2, y1, y2
    localparam logic [3:0] PINS_IDLE    = 4'b0110;
    localparam logic [3:0] PINS_DRIVE_Y = 4'b0101;
    localparam logic [3:0] PINS_DRIVE_X = 4'b1010;

    localparam logic [POS_W-1:0] NO_TOUCH = {POS_W{1'b1}};

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MAX_X = 3'd1,
        REG_MIN_Y = 3'd2,
        REG_MAX_Y = 3'd3,
        REG_STEP  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        CH_X1 = 2'd0,
        CH_X2 = 2'd1,
        CH_Y1 = 2'd2,
        CH_Y2 = 2'd3
    } chan_t;

    typedef enum logic [3:0] {
        PH_DRIVE_Y  = 4'd0,
        PH_START_X1 = 4'd1,
        PH_READ_X1  = 4'd2,
        PH_START_X2 = 4'd3,
        PH_READ_X2  = 4'd4,
        PH_DRIVE_X  = 4'd5,
        PH_START_Y1 = 4'd6,
        PH_READ_Y1  = 4'd7,
        PH_START_Y2 = 4'd8,
        PH_READ_Y2  = 4'd9,
        PH_COMPUTE  = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_MUL_X  = 3'd1,
        ST_GO_X   = 3'd2,
        ST_WAIT_X = 3'd3,
        ST_MUL_Y  = 3'd4,
        ST_GO_Y   = 3'd5,
        ST_WAIT_Y = 3'd6,
        ST_LOAD   = 3'd7
    } fsm_t;

    typedef struct packed {
        logic mul_en;
        logic mul_sel_y;
        logic div_start;
        logic cap_x;
        logic cap_y;
        logic load_late;
    } ctl_t;

endpackage
`default_nettype wire

>>> design/rtsc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rtsc_div #(
    parameter int DVS_W = rtsc_pkg::SAMPLE_W,
    parameter int QUO_W = rtsc_pkg::QUO_W,
    parameter int DVD_W = DVS_W + QUO_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [QUO_W-1:0] quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = dividend[DVD_W-1:QUO_W];
            quo_next = dividend[QUO_W-1:0];
            dvs_next = divisor;
            cnt_next = CNT_W'(QUO_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

>>> design/resistive_touch_scan_controller.sv
// Top level: four-wire resistive touch panel scan sequencer with APB registers.
// Each word taken gives its output word in the next cycle; a compute word that finds a touch
//   instead runs, per axis, multiply, divider load, the quotient bits and capture, then load.
// Throughput: one word per cycle while the output drains and no touch compute runs;
//   after a touch compute the next word is taken once its result word is loaded.
// Reset: rst_n asynchronous, active low; restores registers, phase, pins and position.
`timescale 1ns / 1ps
`default_nettype none
module resistive_touch_scan_controller #(
    parameter int SCREEN_WIDTH  = rtsc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = rtsc_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rtsc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [rtsc_pkg::DATA_W-1:0]   pwdata,
    output logic      [rtsc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          adc_ready,
    input  wire logic [rtsc_pkg::SAMPLE_W-1:0] adc_sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               x1_drive,
    output logic                               x2_drive,
    output logic                               y1_drive,
    output logic                               y2_drive,
    output logic                               adc_start,
    output logic      [1:0]                    adc_channel,
    output logic signed [rtsc_pkg::POS_W-1:0]  touch_x,
    output logic signed [rtsc_pkg::POS_W-1:0]  touch_y,
    output logic                               touched
);

    localparam int SW = rtsc_pkg::SAMPLE_W;
    localparam int TW = rtsc_pkg::TICK_W;
    localparam int PW = rtsc_pkg::POS_W;
    localparam int ZW = rtsc_pkg::SIZE_W;
    localparam int MW = rtsc_pkg::PROD_W;
    localparam int QW = rtsc_pkg::QUO_W;
    localparam logic [ZW-1:0] SIZE_X = ZW'(SCREEN_WIDTH);
    localparam logic [ZW-1:0] SIZE_Y = ZW'(SCREEN_HEIGHT);

    rtsc_pkg::fsm_t   state_reg, state_next;
    rtsc_pkg::phase_t phase_reg, phase_next;
    rtsc_pkg::ctl_t   ctl;

    logic [SW-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [TW-1:0] step_reg;
    logic [TW-1:0] tick_reg, tick_next;
    logic [SW-1:0] raw_x1_reg, raw_x1_next, raw_x2_reg, raw_x2_next;
    logic [SW-1:0] raw_y1_reg, raw_y1_next, raw_y2_reg, raw_y2_next;
    logic [3:0]    pin_reg, pin_next;
    logic [PW-1:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [SW-1:0] off_x_reg, off_x_next, off_y_reg, off_y_next;
    logic [SW-1:0] span_x_reg, span_x_next, span_y_reg, span_y_next;
    logic [MW-1:0] prod_reg, prod_next;

    logic          out_valid_reg, out_valid_next;
    logic [3:0]    out_pin_reg, out_pin_next;
    logic          out_start_reg, out_start_next;
    logic [1:0]    out_chan_reg, out_chan_next;
    logic [PW-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic          out_touch_reg, out_touch_next;

    logic          cfg_wr;
    logic          acc;
    logic          out_free;
    logic          comp_go;
    logic [TW-1:0] elapsed;
    logic          step;
    logic [SW:0]   sum_x, sum_y;
    logic [SW-1:0] avg_x, avg_y;
    logic          bad;
    logic          start_now;
    logic [1:0]    chan_now;
    logic          div_done;
    logic [QW-1:0] div_quo;
    logic [ZW-1:0] size_sel;
    logic [PW-1:0] clamp_q;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (rtsc_pkg::reg_idx_t'(paddr[4:2]))
            rtsc_pkg::REG_MIN_X: prdata = rtsc_pkg::DATA_W'(min_x_reg);
            rtsc_pkg::REG_MAX_X: prdata = rtsc_pkg::DATA_W'(max_x_reg);
            rtsc_pkg::REG_MIN_Y: prdata = rtsc_pkg::DATA_W'(min_y_reg);
            rtsc_pkg::REG_MAX_Y: prdata = rtsc_pkg::DATA_W'(max_y_reg);
            rtsc_pkg::REG_STEP:  prdata = rtsc_pkg::DATA_W'(step_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= rtsc_pkg::RST_MIN_X;
            max_x_reg <= rtsc_pkg::RST_MAX_X;
            min_y_reg <= rtsc_pkg::RST_MIN_Y;
            max_y_reg <= rtsc_pkg::RST_MAX_Y;
            step_reg  <= rtsc_pkg::RST_STEP;
        end
        else if (cfg_wr)
        begin
            unique case (rtsc_pkg::reg_idx_t'(paddr[4:2]))
                rtsc_pkg::REG_MIN_X: min_x_reg <= pwdata[SW-1:0];
                rtsc_pkg::REG_MAX_X: max_x_reg <= pwdata[SW-1:0];
                rtsc_pkg::REG_MIN_Y: min_y_reg <= pwdata[SW-1:0];
                rtsc_pkg::REG_MAX_Y: max_y_reg <= pwdata[SW-1:0];
                rtsc_pkg::REG_STEP:  step_reg  <= pwdata[TW-1:0];
                default:             ;
            endcase
        end
    end

    // handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != rtsc_pkg::ST_IDLE) || !out_free;
    assign acc      = in_valid && !in_stall;

    assign elapsed = (tick_reg != rtsc_pkg::TICK_MAX) ? tick_reg + TW'(1) : tick_reg;
    assign step    = adc_ready && (elapsed >= step_reg);

    assign sum_x = {1'b0, raw_x1_reg} + {1'b0, raw_x2_reg};
    assign sum_y = {1'b0, raw_y1_reg} + {1'b0, raw_y2_reg};
    assign avg_x = sum_x[SW:1];
    assign avg_y = sum_y[SW:1];
    assign bad   = (max_x_reg <= min_x_reg) || (max_y_reg <= min_y_reg) ||
                   (avg_x < min_x_reg) || (avg_x > max_x_reg) ||
                   (avg_y < min_y_reg) || (avg_y > max_y_reg);

    assign comp_go = acc && step && (phase_reg == rtsc_pkg::PH_COMPUTE) && !bad;

    // position sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rtsc_pkg::ST_IDLE:   if (comp_go) state_next = rtsc_pkg::ST_MUL_X;
            rtsc_pkg::ST_MUL_X:  state_next = rtsc_pkg::ST_GO_X;
            rtsc_pkg::ST_GO_X:   state_next = rtsc_pkg::ST_WAIT_X;
            rtsc_pkg::ST_WAIT_X: if (div_done) state_next = rtsc_pkg::ST_MUL_Y;
            rtsc_pkg::ST_MUL_Y:  state_next = rtsc_pkg::ST_GO_Y;
            rtsc_pkg::ST_GO_Y:   state_next = rtsc_pkg::ST_WAIT_Y;
            rtsc_pkg::ST_WAIT_Y: if (div_done) state_next = rtsc_pkg::ST_LOAD;
            rtsc_pkg::ST_LOAD:   if (out_free) state_next = rtsc_pkg::ST_IDLE;
            default:             state_next = rtsc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            rtsc_pkg::ST_MUL_X:  ctl.mul_en = 1'b1;
            rtsc_pkg::ST_GO_X:   ctl.div_start = 1'b1;
            rtsc_pkg::ST_WAIT_X: ctl.cap_x = div_done;
            rtsc_pkg::ST_MUL_Y:
            begin
                ctl.mul_en    = 1'b1;
                ctl.mul_sel_y = 1'b1;
            end
            rtsc_pkg::ST_GO_Y:   ctl.div_start = 1'b1;
            rtsc_pkg::ST_WAIT_Y: ctl.cap_y = div_done;
            rtsc_pkg::ST_LOAD:   ctl.load_late = out_free;
            default:             ;
        endcase
    end

    assign size_sel = ctl.mul_sel_y ? SIZE_Y : SIZE_X;

    rtsc_div #(
        .DVS_W (SW),
        .QUO_W (QW),
        .DVD_W (MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (prod_reg),
        .divisor  (ctl.mul_sel_y || state_reg == rtsc_pkg::ST_GO_Y ? span_y_reg : span_x_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        if (ctl.cap_y)
            clamp_q = (div_quo >= SIZE_Y) ? PW'(SIZE_Y - ZW'(1)) : PW'(div_quo);
        else
            clamp_q = (div_quo >= SIZE_X) ? PW'(SIZE_X - ZW'(1)) : PW'(div_quo);
    end

    // step datapath
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        raw_x1_next = raw_x1_reg;
        raw_x2_next = raw_x2_reg;
        raw_y1_next = raw_y1_reg;
        raw_y2_next = raw_y2_reg;
        pin_next    = pin_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        off_x_next  = off_x_reg;
        off_y_next  = off_y_reg;
        span_x_next = span_x_reg;
        span_y_next = span_y_reg;
        prod_next   = prod_reg;
        start_now   = 1'b0;
        chan_now    = rtsc_pkg::CH_X1;

        if (acc)
        begin
            if (step)
            begin
                tick_next = '0;
                case (phase_reg)
                    rtsc_pkg::PH_DRIVE_Y:  pin_next = rtsc_pkg::PINS_DRIVE_Y;
                    rtsc_pkg::PH_START_X1:
                    begin
                        start_now = 1'b1;
                        chan_now  = rtsc_pkg::CH_X1;
                    end
                    rtsc_pkg::PH_READ_X1:  raw_x1_next = ~adc_sample;
                    rtsc_pkg::PH_START_X2:
                    begin
                        start_now = 1'b1;
                        chan_now  = rtsc_pkg::CH_X2;
                    end
                    rtsc_pkg::PH_READ_X2:  raw_x2_next = ~adc_sample;
                    rtsc_pkg::PH_DRIVE_X:  pin_next = rtsc_pkg::PINS_DRIVE_X;
                    rtsc_pkg::PH_START_Y1:
                    begin
                        start_now = 1'b1;
                        chan_now  = rtsc_pkg::CH_Y1;
                    end
                    rtsc_pkg::PH_READ_Y1:  raw_y1_next = ~adc_sample;
                    rtsc_pkg::PH_START_Y2:
                    begin
                        start_now = 1'b1;
                        chan_now  = rtsc_pkg::CH_Y2;
                    end
                    rtsc_pkg::PH_READ_Y2:  raw_y2_next = ~adc_sample;
                    rtsc_pkg::PH_COMPUTE:
                    begin
                        if (bad)
                        begin
                            pos_x_next = rtsc_pkg::NO_TOUCH;
                            pos_y_next = rtsc_pkg::NO_TOUCH;
                        end
                        else
                        begin
                            off_x_next  = avg_x - min_x_reg;
                            off_y_next  = avg_y - min_y_reg;
                            span_x_next = max_x_reg - min_x_reg;
                            span_y_next = max_y_reg - min_y_reg;
                        end
                    end
                    default: ;
                endcase
                phase_next = (phase_reg >= rtsc_pkg::PH_COMPUTE) ? rtsc_pkg::PH_DRIVE_Y
                           : rtsc_pkg::phase_t'(phase_reg + 4'd1);
            end
            else
                tick_next = elapsed;
        end

        if (ctl.mul_en)
            prod_next = MW'(ctl.mul_sel_y ? off_y_reg : off_x_reg) * MW'(size_sel);
        if (ctl.cap_x)
            pos_x_next = clamp_q;
        if (ctl.cap_y)
            pos_y_next = clamp_q;
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_pin_next   = out_pin_reg;
        out_start_next = out_start_reg;
        out_chan_next  = out_chan_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_touch_next = out_touch_reg;
        if (acc && !comp_go)
        begin
            out_valid_next = 1'b1;
            out_pin_next   = pin_next;
            out_start_next = start_now;
            out_chan_next  = chan_now;
            out_x_next     = pos_x_next;
            out_y_next     = pos_y_next;
            out_touch_next = (pos_x_next != rtsc_pkg::NO_TOUCH) &&
                             (pos_y_next != rtsc_pkg::NO_TOUCH);
        end
        else if (ctl.load_late)
        begin
            out_valid_next = 1'b1;
            out_pin_next   = pin_reg;
            out_start_next = 1'b0;
            out_chan_next  = rtsc_pkg::CH_X1;
            out_x_next     = pos_x_reg;
            out_y_next     = pos_y_reg;
            out_touch_next = (pos_x_reg != rtsc_pkg::NO_TOUCH) &&
                             (pos_y_reg != rtsc_pkg::NO_TOUCH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtsc_pkg::ST_IDLE;
            phase_reg     <= rtsc_pkg::PH_DRIVE_Y;
            tick_reg      <= '0;
            raw_x1_reg    <= '0;
            raw_x2_reg    <= '0;
            raw_y1_reg    <= '0;
            raw_y2_reg    <= '0;
            pin_reg       <= rtsc_pkg::PINS_IDLE;
            pos_x_reg     <= rtsc_pkg::NO_TOUCH;
            pos_y_reg     <= rtsc_pkg::NO_TOUCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            raw_x1_reg    <= raw_x1_next;
            raw_x2_reg    <= raw_x2_next;
            raw_y1_reg    <= raw_y1_next;
            raw_y2_reg    <= raw_y2_next;
            pin_reg       <= pin_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_x_reg     <= off_x_next;
        off_y_reg     <= off_y_next;
        span_x_reg    <= span_x_next;
        span_y_reg    <= span_y_next;
        prod_reg      <= prod_next;
        out_pin_reg   <= out_pin_next;
        out_start_reg <= out_start_next;
        out_chan_reg  <= out_chan_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_touch_reg <= out_touch_next;
    end

    assign out_valid   = out_valid_reg;
    assign x1_drive    = out_pin_reg[3];
    assign x2_drive    = out_pin_reg[2];
    assign y1_drive    = out_pin_reg[1];
    assign y2_drive    = out_pin_reg[0];
    assign adc_start   = out_start_reg;
    assign adc_channel = out_chan_reg;
    assign touch_x     = out_x_reg;
    assign touch_y     = out_y_reg;
    assign touched     = out_touch_reg;

endmodule
`default_nettype wire

>>> design/rtsc_checker.sv
// Port-level checks for the touch scan controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rtsc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              x1_drive,
    input wire logic                              x2_drive,
    input wire logic                              y1_drive,
    input wire logic                              y2_drive,
    input wire logic                              adc_start,
    input wire logic [1:0]                        adc_channel,
    input wire logic signed [rtsc_pkg::POS_W-1:0] touch_x,
    input wire logic signed [rtsc_pkg::POS_W-1:0] touch_y,
    input wire logic                              touched
);

    a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(touch_x) && $stable(touch_y))
        else $error("stalled word dropped or changed");

    a_idle_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !adc_start |-> adc_channel == rtsc_pkg::CH_X1)
        else $error("channel set without a conversion start");

    a_x_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && adc_start && !adc_channel[1] |->
            !x1_drive && x2_drive && !y1_drive && y2_drive)
        else $error("X conversion started without Y axis drive");

    a_y_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && adc_start && adc_channel[1] |->
            x1_drive && !x2_drive && y1_drive && !y2_drive)
        else $error("Y conversion started without X axis drive");

    a_touch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && touched |-> !touch_x[rtsc_pkg::POS_W-1] && !touch_y[rtsc_pkg::POS_W-1])
        else $error("touch flagged with a negative coordinate");

endmodule

bind resistive_touch_scan_controller rtsc_checker u_rtsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x1_drive    (x1_drive),
    .x2_drive    (x2_drive),
    .y1_drive    (y1_drive),
    .y2_drive    (y2_drive),
    .adc_start   (adc_start),
    .adc_channel (adc_channel),
    .touch_x     (touch_x),
    .touch_y     (touch_y),
    .touched     (touched)
);
`default_nettype wire

>>> verif/resistive_touch_scan_controller_test.sv
// Self-checking testbench for the resistive touch scan controller.
`timescale 1ns / 1ps
module resistive_touch_scan_controller_test;

    localparam int SCR_W       = rtsc_pkg::DEF_SCREEN_WIDTH;
    localparam int SCR_H       = rtsc_pkg::DEF_SCREEN_HEIGHT;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYC  = 40;
    localparam int PHASE_WORDS = 123;
    localparam int NUM_PHASES  = 6;
    localparam int LONG_IVL    = 40;

    typedef struct packed {
        logic [3:0]         pins;
        logic               start;
        rtsc_pkg::chan_t    chan;
        logic signed [12:0] tx;
        logic signed [12:0] ty;
        logic               touched;
    } scan_out_t;

    typedef struct {
        logic        rdy;
        logic [11:0] smp;
        bit          known;
        scan_out_t   want;
    } probe_row_t;

    localparam scan_out_t WANT_IDLE  = '{rtsc_pkg::PINS_IDLE, 1'b0, rtsc_pkg::CH_X1,
                                         rtsc_pkg::NO_TOUCH, rtsc_pkg::NO_TOUCH, 1'b0};
    localparam scan_out_t WANT_CLAMP = '{rtsc_pkg::PINS_DRIVE_X, 1'b0, rtsc_pkg::CH_X1,
                                         13'sd479, 13'sd271, 1'b1};
    localparam scan_out_t WANT_LOST  = '{rtsc_pkg::PINS_DRIVE_X, 1'b0, rtsc_pkg::CH_X1,
                                         rtsc_pkg::NO_TOUCH, rtsc_pkg::NO_TOUCH, 1'b0};

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              psel       = 1'b0;
    logic                              penable    = 1'b0;
    logic                              pwrite     = 1'b0;
    logic [rtsc_pkg::ADDR_W-1:0]       paddr      = '0;
    logic [rtsc_pkg::DATA_W-1:0]       pwdata     = '0;
    logic [rtsc_pkg::DATA_W-1:0]       prdata;
    logic                              pready;
    logic                              in_valid   = 1'b0;
    logic                              in_stall;
    logic                              adc_ready  = 1'b0;
    logic [rtsc_pkg::SAMPLE_W-1:0]     adc_sample = '0;
    logic                              out_valid;
    logic                              out_stall  = 1'b0;
    logic                              x1_drive;
    logic                              x2_drive;
    logic                              y1_drive;
    logic                              y2_drive;
    logic                              adc_start;
    logic [1:0]                        adc_channel;
    logic signed [rtsc_pkg::POS_W-1:0] touch_x;
    logic signed [rtsc_pkg::POS_W-1:0] touch_y;
    logic                              touched;

    // side data that travels with the driven word
    bit                           word_known = 1'b0;
    scan_out_t                    word_want  = '0;

    int in_idle_pct = 0;
    int stall_pct   = 0;

    // predictor state
    logic [11:0]        cfg_min_x, cfg_max_x, cfg_min_y, cfg_max_y;
    logic [15:0]        step_ivl, tick_cnt;
    logic [3:0]         ph, pins;
    logic [11:0]        rx1, rx2, ry1, ry2;
    logic signed [12:0] px, py;

    scan_out_t  due_outputs[$];
    probe_row_t probe_tab[$];

    int fail_count   = 0;
    int words_in     = 0;
    int outs_checked = 0;
    int scan_computes = 0;
    int scan_touches = 0;
    int quiet_cycles = 0;

    resistive_touch_scan_controller #(
        .SCREEN_WIDTH (SCR_W),
        .SCREEN_HEIGHT(SCR_H)
    ) dut (.*);

    always #1 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic reset_scan_model();
        cfg_min_x = rtsc_pkg::RST_MIN_X;
        cfg_max_x = rtsc_pkg::RST_MAX_X;
        cfg_min_y = rtsc_pkg::RST_MIN_Y;
        cfg_max_y = rtsc_pkg::RST_MAX_Y;
        step_ivl  = rtsc_pkg::RST_STEP;
        tick_cnt  = '0;
        ph        = rtsc_pkg::PH_DRIVE_Y;
        pins      = rtsc_pkg::PINS_IDLE;
        rx1 = '0;
        rx2 = '0;
        ry1 = '0;
        ry2 = '0;
        px  = rtsc_pkg::NO_TOUCH;
        py  = rtsc_pkg::NO_TOUCH;
    endtask

    function automatic logic signed [12:0] map_to_screen(int avg, int lo, int hi, int size);
        int v;
        v = ((avg - lo) * size) / (hi - lo);
        if (v >= size)
            v = size - 1;
        return 13'(v);
    endfunction

    function automatic void resolve_touch();
        int ax, ay;
        ax = (int'(rx1) + int'(rx2)) >> 1;
        ay = (int'(ry1) + int'(ry2)) >> 1;
        scan_computes++;
        if (cfg_max_x <= cfg_min_x || cfg_max_y <= cfg_min_y ||
            ax < int'(cfg_min_x) || ax > int'(cfg_max_x) ||
            ay < int'(cfg_min_y) || ay > int'(cfg_max_y))
        begin
            px = rtsc_pkg::NO_TOUCH;
            py = rtsc_pkg::NO_TOUCH;
        end
        else
        begin
            px = map_to_screen(ax, int'(cfg_min_x), int'(cfg_max_x), SCR_W);
            py = map_to_screen(ay, int'(cfg_min_y), int'(cfg_max_y), SCR_H);
            scan_touches++;
        end
    endfunction

    function automatic scan_out_t next_scan_outputs(logic rdy, logic [11:0] smp);
        scan_out_t r;
        logic [15:0] elapsed;
        r = '0;
        elapsed = (tick_cnt == rtsc_pkg::TICK_MAX) ? rtsc_pkg::TICK_MAX : tick_cnt + 16'd1;
        if (rdy && elapsed >= step_ivl)
        begin
            tick_cnt = '0;
            case (rtsc_pkg::phase_t'(ph))
                rtsc_pkg::PH_DRIVE_Y:  pins = rtsc_pkg::PINS_DRIVE_Y;
                rtsc_pkg::PH_START_X1: begin r.start = 1'b1; r.chan = rtsc_pkg::CH_X1; end
                rtsc_pkg::PH_READ_X1:  rx1 = 12'(4095 - int'(smp));
                rtsc_pkg::PH_START_X2: begin r.start = 1'b1; r.chan = rtsc_pkg::CH_X2; end
                rtsc_pkg::PH_READ_X2:  rx2 = 12'(4095 - int'(smp));
                rtsc_pkg::PH_DRIVE_X:  pins = rtsc_pkg::PINS_DRIVE_X;
                rtsc_pkg::PH_START_Y1: begin r.start = 1'b1; r.chan = rtsc_pkg::CH_Y1; end
                rtsc_pkg::PH_READ_Y1:  ry1 = 12'(4095 - int'(smp));
                rtsc_pkg::PH_START_Y2: begin r.start = 1'b1; r.chan = rtsc_pkg::CH_Y2; end
                rtsc_pkg::PH_READ_Y2:  ry2 = 12'(4095 - int'(smp));
                rtsc_pkg::PH_COMPUTE:  resolve_touch();
                default:               ;
            endcase
            ph = (ph >= 4'(rtsc_pkg::PH_COMPUTE)) ? 4'(rtsc_pkg::PH_DRIVE_Y) : ph + 4'd1;
        end
        else
        begin
            tick_cnt = elapsed;
        end
        r.pins    = pins;
        r.tx      = px;
        r.ty      = py;
        r.touched = (px != rtsc_pkg::NO_TOUCH && py != rtsc_pkg::NO_TOUCH);
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic signed [15:0] got, logic signed [15:0] want);
        fail_count++;
        $display("t=%0t result %0d %s: got %0d want %0d", $time, outs_checked, what, got,
                 want);
    endtask

    task automatic check_field(string what, logic signed [15:0] got, logic signed [15:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        scan_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_outputs.size() == 0)
                begin
                    flag_mismatch("result with nothing due", 0, 0);
                end
                else
                begin
                    want = due_outputs.pop_front();
                    check_field("x1_drive", x1_drive, want.pins[3]);
                    check_field("x2_drive", x2_drive, want.pins[2]);
                    check_field("y1_drive", y1_drive, want.pins[1]);
                    check_field("y2_drive", y2_drive, want.pins[0]);
                    check_field("adc_start", adc_start, want.start);
                    check_field("adc_channel", adc_channel, want.chan);
                    check_field("touch_x", touch_x, $signed(want.tx));
                    check_field("touch_y", touch_y, $signed(want.ty));
                    check_field("touched", touched, want.touched);
                end
                outs_checked++;
            end
            if (in_valid && !in_stall)
            begin
                want = next_scan_outputs(adc_ready, adc_sample);
                if (word_known)
                    want = word_want;
                due_outputs.push_back(want);
                words_in++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("resistive_touch_scan_controller: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(logic rdy, logic [11:0] smp, bit known, scan_out_t want);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_ready  <= rdy;
        adc_sample <= smp;
        word_known <= known;
        word_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random_word();
        logic        rdy;
        logic [11:0] smp;
        int          lo, hi, pick;
        rdy = ($urandom_range(99) < 80);
        if (ph <= 4'(rtsc_pkg::PH_READ_X2))
        begin
            lo = cfg_min_x;
            hi = cfg_max_x;
        end
        else
        begin
            lo = cfg_min_y;
            hi = cfg_max_y;
        end
        pick = $urandom_range(99);
        if (pick < 60)
            smp = 12'(4095 - int'($urandom_range(lo, hi)));
        else if (pick < 75)
            case ($urandom_range(3))
                0:       smp = 12'd0;
                1:       smp = 12'd4095;
                2:       smp = 12'(4095 - lo);
                default: smp = 12'(4095 - hi);
            endcase
        else
            smp = 12'($urandom);
        send_word(rdy, smp, 1'b0, '0);
    endtask

    task automatic cfg_write(rtsc_pkg::reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rtsc_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            rtsc_pkg::REG_MIN_X: cfg_min_x = val[11:0];
            rtsc_pkg::REG_MAX_X: cfg_max_x = val[11:0];
            rtsc_pkg::REG_MIN_Y: cfg_min_y = val[11:0];
            rtsc_pkg::REG_MAX_Y: cfg_max_y = val[11:0];
            rtsc_pkg::REG_STEP:  step_ivl  = val[15:0];
            default:             ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits carry junk the block must ignore
    task automatic set_window(int mnx, int mxx, int mny, int mxy, int ivl);
        cfg_write(rtsc_pkg::REG_MIN_X, {20'($urandom), 12'(mnx)});
        cfg_write(rtsc_pkg::REG_MAX_X, {20'($urandom), 12'(mxx)});
        cfg_write(rtsc_pkg::REG_MIN_Y, {20'($urandom), 12'(mny)});
        cfg_write(rtsc_pkg::REG_MAX_Y, {20'($urandom), 12'(mxy)});
        cfg_write(rtsc_pkg::REG_STEP,  {16'($urandom), 16'(ivl)});
    endtask

    // hold the input, let every due result arrive, then let the compute path go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic add_probe(logic rdy, logic [11:0] smp, bit known, scan_out_t want);
        probe_row_t row;
        row.rdy   = rdy;
        row.smp   = smp;
        row.known = known;
        row.want  = want;
        probe_tab.push_back(row);
    endtask

    initial
    begin
        int lo, hi;

        reset_scan_model();

        // idle after reset, then a full scan with both axes at the window top
        add_probe(1'b0, 12'd4095, 1'b1, WANT_IDLE);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd4095, 1'b0, '0);
        add_probe(1'b1, 12'd195,  1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd195,  1'b0, '0);
        add_probe(1'b1, 12'd4095, 1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd245,  1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd245,  1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b1, WANT_CLAMP);
        // X at the window origin, Y above the window: touch lost
        add_probe(1'b0, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd4095, 1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd3905, 1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd3905, 1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd4095, 1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd4095, 1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b0, '0);
        add_probe(1'b1, 12'd0,    1'b1, WANT_LOST);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probe_tab[i])
            send_word(probe_tab[i].rdy, probe_tab[i].smp, probe_tab[i].known,
                      probe_tab[i].want);
        settle();

        // long interval: step right at the limit, then again after a longer wait
        set_window(rtsc_pkg::RST_MIN_X, rtsc_pkg::RST_MAX_X, rtsc_pkg::RST_MIN_Y,
                   rtsc_pkg::RST_MAX_Y, LONG_IVL);
        repeat (LONG_IVL - 2) send_word(1'b0, 12'($urandom), 1'b0, '0);
        repeat (2) send_word(1'b1, 12'($urandom), 1'b0, '0);
        repeat (LONG_IVL + 8) send_word(1'b0, 12'($urandom), 1'b0, '0);
        repeat (2) send_word(1'b1, 12'($urandom), 1'b0, '0);
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: set_window(0, 4095, 0, 4095, 0);
                1: set_window(rtsc_pkg::RST_MIN_X, rtsc_pkg::RST_MAX_X, rtsc_pkg::RST_MIN_Y,
                              rtsc_pkg::RST_MAX_Y, 1);
                2: set_window(2047, 2048, 4094, 4095, 3);
                3: set_window(3000, 1000, 180, 3850, 1);
                4:
                begin
                    lo = $urandom_range(0, 4000);
                    hi = $urandom_range(lo + 1, 4095);
                    set_window(lo, hi, hi - lo, 4095, $urandom_range(1, 4));
                end
                default: set_window(0, 4095, 4095, 4095, 2);
            endcase
            case (p % 4)
                0:       begin in_idle_pct = 0;  stall_pct = 0;  end
                1:       begin in_idle_pct = 55; stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  stall_pct = 55; end
                default: begin in_idle_pct = 36; stall_pct = 36; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n == PHASE_WORDS / 2)
                    settle();
                send_random_word();
            end
            in_idle_pct = 0;
            stall_pct   = 0;
            settle();
        end

        $display("Scanned %0d ticks, checked %0d results, %0d compute steps (%0d touches).",
                 words_in, outs_checked, scan_computes, scan_touches);
        $display("Step intervals 0 to %0d ran over full, narrow, inverted and empty windows.",
                 LONG_IVL);
        if (fail_count == 0)
            $display("resistive_touch_scan_controller: match");
        else
            $display("resistive_touch_scan_controller: mismatch");
        $finish;
    end

endmodule
